### hdl/rvex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and constants for the RV32I execute unit: operation codes,
// datapath widths and data memory lane layout.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam int XLEN     = 32;
  localparam int REG_AW   = 5;
  localparam int NUM_REGS = 32;
  localparam int LANES    = 4;
  localparam int LANE_AW  = 2;
  localparam int BYTE_W   = 8;

  localparam int DMEM_BYTES_DEFAULT = 65536;

  localparam logic [XLEN-1:0] PC_STEP = 32'd4;
  localparam int              LUI_SHIFT = 12;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADDI  = 5'd1,
    OP_SUB   = 5'd2,
    OP_AND   = 5'd3,
    OP_ANDI  = 5'd4,
    OP_OR    = 5'd5,
    OP_ORI   = 5'd6,
    OP_XOR   = 5'd7,
    OP_XORI  = 5'd8,
    OP_SLTI  = 5'd9,
    OP_SLTIU = 5'd10,
    OP_SLLI  = 5'd11,
    OP_SRLI  = 5'd12,
    OP_SRAI  = 5'd13,
    OP_LB    = 5'd14,
    OP_LH    = 5'd15,
    OP_LW    = 5'd16,
    OP_SB    = 5'd17,
    OP_SH    = 5'd18,
    OP_SW    = 5'd19,
    OP_LUI   = 5'd20,
    OP_JAL   = 5'd21,
    OP_JALR  = 5'd22,
    OP_BEQ   = 5'd23,
    OP_BNE   = 5'd24,
    OP_BLT   = 5'd25,
    OP_BGE   = 5'd26,
    OP_BLTU  = 5'd27,
    OP_BGEU  = 5'd28
  } op_t;

endpackage
`default_nettype wire

### hdl/rv32i_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// Executes one decoded RV32I instruction per item against a 32-entry
// register file, the program counter and a byte-addressed data memory.
//
// Usage:
//   inst channel (inst_valid/inst_ready) carries mode, source and destination
//   register numbers and the immediate; res channel (res_valid/res_ready)
//   returns next pc, write-back and branch information, one result per item.
//   Path: an accepted item passes stage 1, stage 2 and the output register.
//   Throughput: one item per cycle unless the clear sweep or a stall holds
//   inst_ready low, as the two-port register file read, the ALU / data
//   memory access stage and the load-format stage are pipelined.
//   Stages: register file read, execute and data memory access, load
//   format and register write-back, output register.
//   Reset: pc and the register file read as zero at once; the data memory is
//   then swept to zero one row of four bytes per cycle, from row 0 to the
//   last row, while inst_ready stays low.
//   Stall: when res_ready is low the stages fill up behind the output
//   register and inst_ready drops once all are full.
//   DMEM_BYTES is a power of two; byte addresses wrap modulo DMEM_BYTES.
// ----------------------------------------------------------------------------
module rv32i_execute_unit
  import rvex_pkg::*;
#(
  parameter int DMEM_BYTES = DMEM_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     inst_valid,
  output logic                     inst_ready,
  input  logic [4:0]               mode,
  input  logic [REG_AW-1:0]        src1_index,
  input  logic [REG_AW-1:0]        src2_index,
  input  logic [REG_AW-1:0]        dest_index,
  input  logic signed [XLEN-1:0]   immediate,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [XLEN-1:0]          next_pc,
  output logic                     wb_valid,
  output logic [REG_AW-1:0]        wb_index,
  output logic [XLEN-1:0]          wb_value,
  output logic                     branch_taken
);

  localparam int DMEM_AW = $clog2(DMEM_BYTES);
  localparam int ROW_AW  = DMEM_AW - LANE_AW;
  localparam int ROWS    = DMEM_BYTES / LANES;

  // memory clear sweep
  logic              clr_busy;
  logic [ROW_AW-1:0] clr_row;

  // handshake and stage control
  logic accept;
  logic s1_valid, s1_take, s1_advance;
  logic s2_valid, s2_take, s2_advance;
  logic out_take;

  // stage 1
  logic [4:0]        s1_mode;
  logic [REG_AW-1:0] s1_src1, s1_src2, s1_dest;
  logic [XLEN-1:0]   s1_imm;
  logic [XLEN-1:0]   rf_q1, rf_q2;
  logic              rf_v1, rf_v2;

  // register file
  logic [XLEN-1:0]   rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic              rf_we;
  logic [REG_AW-1:0] rf_wa;
  logic [XLEN-1:0]   rf_wd;

  // program counter
  logic [XLEN-1:0] pc;

  // execute
  logic [XLEN-1:0]  op1, op2, sum, pc_plus, pc_rel, target;
  logic [XLEN-1:0]  alu, s1_next_pc;
  logic             writes, is_load, is_store, is_branch, is_jump, cond, taken;
  logic             s1_wb;
  logic [LANE_AW-1:0] st_last;
  logic [LANE_AW-1:0] a_lo;
  logic [ROW_AW-1:0]  row_base;

  // data memory lanes
  logic [ROW_AW-1:0] bank_row [LANES];
  logic              bank_we  [LANES];
  logic [BYTE_W-1:0] bank_wd  [LANES];
  logic [BYTE_W-1:0] dm_q     [LANES];
  logic              dm_re;

  // stage 2
  logic [4:0]         s2_mode;
  logic [XLEN-1:0]    s2_alu, s2_next_pc, s2_value, ld_value;
  logic               s2_wb, s2_taken;
  logic [REG_AW-1:0]  s2_index;
  logic [LANE_AW-1:0] s2_lo;
  logic [BYTE_W-1:0]  ld_byte [LANES];

  // ---------------------------------------------------------------- control
  assign out_take   = !res_valid || res_ready;
  assign s2_advance = s2_valid && out_take;
  assign s2_take    = !s2_valid || s2_advance;
  assign s1_advance = s1_valid && s2_take;
  assign s1_take    = !s1_valid || s1_advance;
  assign inst_ready = !clr_busy && s1_take;
  assign accept     = inst_valid && inst_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      clr_row <= clr_row + ROW_AW'(1);
      if (clr_row == ROW_AW'(ROWS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      pc        <= '0;
    end else begin
      if (s1_take) begin
        s1_valid <= accept;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
      if (out_take) begin
        res_valid <= s2_valid;
      end
      if (s1_advance) begin
        pc <= s1_next_pc;
      end
    end
  end

  // ---------------------------------------------------------- register file
  assign rf_we = s2_advance && s2_wb;
  assign rf_wa = s2_index;
  assign rf_wd = s2_value;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (accept) begin
      rf_q1   <= (rf_we && rf_wa == src1_index) ? rf_wd : rf_mem[src1_index];
      rf_q2   <= (rf_we && rf_wa == src2_index) ? rf_wd : rf_mem[src2_index];
      s1_mode <= mode;
      s1_src1 <= src1_index;
      s1_src2 <= src2_index;
      s1_dest <= dest_index;
      s1_imm  <= $unsigned(immediate);
    end
  end

  // entries not yet written read as zero; x0 is never written
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      rf_v1  <= 1'b0;
      rf_v2  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld[rf_wa] <= 1'b1;
      end
      if (accept) begin
        rf_v1 <= rf_vld[src1_index] || (rf_we && rf_wa == src1_index);
        rf_v2 <= rf_vld[src2_index] || (rf_we && rf_wa == src2_index);
      end
    end
  end

  // ---------------------------------------------------------------- execute
  always_comb begin
    if (s2_valid && s2_wb && s2_index == s1_src1) begin
      op1 = s2_value;
    end else begin
      op1 = rf_v1 ? rf_q1 : '0;
    end
    if (s2_valid && s2_wb && s2_index == s1_src2) begin
      op2 = s2_value;
    end else begin
      op2 = rf_v2 ? rf_q2 : '0;
    end
  end

  assign sum     = op1 + s1_imm;
  assign pc_plus = pc + PC_STEP;
  assign pc_rel  = pc + s1_imm;

  always_comb begin
    alu       = '0;
    writes    = 1'b0;
    is_load   = 1'b0;
    is_store  = 1'b0;
    is_branch = 1'b0;
    is_jump   = 1'b0;
    cond      = 1'b0;
    st_last   = '0;
    target    = pc_rel;
    unique case (s1_mode)
      OP_ADD: begin
        alu = op1 + op2; writes = 1'b1;
      end
      OP_ADDI: begin
        alu = sum; writes = 1'b1;
      end
      OP_SUB: begin
        alu = op1 - op2; writes = 1'b1;
      end
      OP_AND: begin
        alu = op1 & op2; writes = 1'b1;
      end
      OP_ANDI: begin
        alu = op1 & s1_imm; writes = 1'b1;
      end
      OP_OR: begin
        alu = op1 | op2; writes = 1'b1;
      end
      OP_ORI: begin
        alu = op1 | s1_imm; writes = 1'b1;
      end
      OP_XOR: begin
        alu = op1 ^ op2; writes = 1'b1;
      end
      OP_XORI: begin
        alu = op1 ^ s1_imm; writes = 1'b1;
      end
      OP_SLTI: begin
        alu = XLEN'($signed(op1) < $signed(s1_imm)); writes = 1'b1;
      end
      OP_SLTIU: begin
        alu = XLEN'(op1 < s1_imm); writes = 1'b1;
      end
      OP_SLLI: begin
        alu = op1 << s1_imm[4:0]; writes = 1'b1;
      end
      OP_SRLI: begin
        alu = op1 >> s1_imm[4:0]; writes = 1'b1;
      end
      OP_SRAI: begin
        alu = XLEN'($signed(op1) >>> s1_imm[4:0]); writes = 1'b1;
      end
      OP_LB, OP_LH, OP_LW: begin
        is_load = 1'b1; writes = 1'b1;
      end
      OP_SB: begin
        is_store = 1'b1; st_last = LANE_AW'(0);
      end
      OP_SH: begin
        is_store = 1'b1; st_last = LANE_AW'(1);
      end
      OP_SW: begin
        is_store = 1'b1; st_last = LANE_AW'(LANES - 1);
      end
      OP_LUI: begin
        alu = s1_imm << LUI_SHIFT; writes = 1'b1;
      end
      OP_JAL: begin
        alu = pc_plus; writes = 1'b1; is_jump = 1'b1;
      end
      OP_JALR: begin
        alu = pc_plus; writes = 1'b1; is_jump = 1'b1;
        target = {sum[XLEN-1:1], 1'b0};
      end
      OP_BEQ: begin
        is_branch = 1'b1; cond = (op1 == op2);
      end
      OP_BNE: begin
        is_branch = 1'b1; cond = (op1 != op2);
      end
      OP_BLT: begin
        is_branch = 1'b1; cond = ($signed(op1) < $signed(op2));
      end
      OP_BGE: begin
        is_branch = 1'b1; cond = !($signed(op1) < $signed(op2));
      end
      OP_BLTU: begin
        is_branch = 1'b1; cond = (op1 < op2);
      end
      OP_BGEU: begin
        is_branch = 1'b1; cond = (op1 >= op2);
      end
      default: begin
      end
    endcase
  end

  assign taken      = is_jump || (is_branch && cond);
  assign s1_next_pc = taken ? target : pc_plus;
  assign s1_wb      = writes && (s1_dest != '0);

  // ------------------------------------------------------------ data memory
  assign a_lo     = sum[LANE_AW-1:0];
  assign row_base = sum[DMEM_AW-1:LANE_AW];
  assign dm_re    = s1_advance && is_load;

  always_comb begin
    logic [LANE_AW-1:0] bi;
    logic [XLEN-1:0]    shd;
    for (int l = 0; l < LANES; l++) begin
      bi  = LANE_AW'(l) - a_lo;
      shd = op2 >> {bi, 3'b000};
      if (clr_busy) begin
        bank_row[l] = clr_row;
        bank_we[l]  = 1'b1;
        bank_wd[l]  = '0;
      end else begin
        bank_row[l] = row_base + ROW_AW'(LANE_AW'(l) < a_lo);
        bank_we[l]  = s1_advance && is_store && (bi <= st_last);
        bank_wd[l]  = shd[BYTE_W-1:0];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [BYTE_W-1:0] bank [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[l]) begin
        bank[bank_row[l]] <= bank_wd[l];
      end
      if (dm_re) begin
        dm_q[l] <= bank[bank_row[l]];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_mode    <= s1_mode;
      s2_alu     <= alu;
      s2_next_pc <= s1_next_pc;
      s2_wb      <= s1_wb;
      s2_index   <= s1_wb ? s1_dest : '0;
      s2_taken   <= taken;
      s2_lo      <= a_lo;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ld_byte[i] = dm_q[LANE_AW'(s2_lo + LANE_AW'(i))];
    end
    unique case (s2_mode)
      OP_LB:   ld_value = {{(XLEN-BYTE_W){ld_byte[0][BYTE_W-1]}}, ld_byte[0]};
      OP_LH:   ld_value = {{(XLEN-2*BYTE_W){ld_byte[1][BYTE_W-1]}}, ld_byte[1], ld_byte[0]};
      OP_LW:   ld_value = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
      default: ld_value = s2_alu;
    endcase
    s2_value = s2_wb ? ld_value : '0;
  end

  // --------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (out_take) begin
      next_pc      <= s2_next_pc;
      wb_valid     <= s2_wb;
      wb_index     <= s2_index;
      wb_value     <= s2_value;
      branch_taken <= s2_taken;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_store_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !(s1_advance && is_store))
    else $error("store reached data memory during clear sweep");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> rf_wa != '0)
    else $error("register file write to x0");

  a_s2_item_kept: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_advance |=> s2_valid)
    else $error("stage 2 item lost while stalled");

  a_wb_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && wb_valid |-> wb_index != '0)
    else $error("write-back reported for x0");
`endif

endmodule
`default_nettype wire
